@@ src/cds_pkg.sv @@
// Shared constants, types and helpers for the card deck shuffler.
package cds_pkg;

   localparam int DECK_SIZE = 52;
   localparam int CODE_W    = 6;
   localparam int POS_W     = 6;
   localparam int RND_W     = 16;
   localparam int DIVR_W    = POS_W + 1;
   localparam int STEP_W    = $clog2(RND_W);

   localparam logic [DIVR_W-1:0] DECK_SIZE_V = DIVR_W'(DECK_SIZE);
   localparam logic [POS_W-1:0]  TOP_POS     = POS_W'(DECK_SIZE - 1);

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_SWAP  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   typedef struct packed {
      logic load_req;
      logic clear_deck;
      logic rd_read;
      logic rd_swap;
      logic wr_pos;
      logic wr_j;
      logic div_start;
      logic res_init;
      logic res_status;
      logic res_from_a;
      logic emit;
   } cds_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       pos_ok;
      logic       idx_ok;
      logic       div_done;
      logic       out_free;
   } cds_stat_type;

   function automatic logic [3:0] card_value(input logic [CODE_W-1:0] code);
      logic [3:0] hi;
      hi = code[CODE_W-1:2];
      return 4'(4'd2 + hi);
   endfunction

endpackage

@@ src/cds_mod.sv @@
// Iterative remainder unit, one dividend bit per cycle.
module cds_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cds_pkg::RND_W-1:0]   dividend,
   input  logic [cds_pkg::DIVR_W-1:0]  divisor,
   output logic                        done,
   output logic [cds_pkg::POS_W-1:0]   remainder
);
   import cds_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [RND_W-1:0]    dvd_ff, dvd_in;
   logic [DIVR_W-1:0]   dvr_ff, dvr_in;
   logic [POS_W-1:0]    rem_ff, rem_in;
   logic [DIVR_W-1:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvr_in  = dvr_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[RND_W-1]};
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = STEP_W'(RND_W - 1);
         dvd_in  = dividend;
         dvr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[RND_W-2:0], 1'b0};
         if (trial >= dvr_ff) begin
            rem_in = POS_W'(trial - dvr_ff);
         end else begin
            rem_in = trial[POS_W-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvr_ff <= dvr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ src/cds_datapath.sv @@
// Deck memory, swap position, remainder unit and result register.
module cds_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  cds_pkg::cds_cmd_type      cmd,
   output cds_pkg::cds_stat_type     stat,
   input  logic [1:0]                req_tuser,
   input  logic [23:0]               req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [15:0]               rsp_tdata,
   output logic [0:0]                rsp_tuser
);
   import cds_pkg::*;

   logic [CODE_W-1:0]    deck_ff [DECK_SIZE];
   logic [DECK_SIZE-1:0] valid_ff, valid_in;

   logic [1:0]           act_ff;
   logic [RND_W-1:0]     rnd_ff;
   logic [POS_W-1:0]     idx_ff;
   logic [POS_W-1:0]     pos_ff, pos_in;

   logic [POS_W-1:0]     addr_a, addr_b;
   logic [POS_W-1:0]     addr_a_ff, addr_b_ff;
   logic [CODE_W-1:0]    rd_a_ff, rd_b_ff;
   logic                 vld_a_ff, vld_b_ff;
   logic [CODE_W-1:0]    card_a, card_b;
   logic                 rd_en;

   logic [CODE_W-1:0]    res_code_ff, res_code_in;
   logic                 res_has_ff, res_has_in;
   logic                 res_stat_ff, res_stat_in;

   logic                 rsp_valid_ff;
   logic [15:0]          rsp_data_ff;
   logic                 rsp_user_ff;
   logic [3:0]           out_value;
   logic [1:0]           out_suit;

   logic                 div_done;
   logic [POS_W-1:0]     rem;

   cds_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (rnd_ff),
      .divisor   ({1'b0, pos_ff} + DIVR_W'(1)),
      .done      (div_done),
      .remainder (rem)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff <= req_tuser;
         rnd_ff <= req_tdata[RND_W-1:0];
         idx_ff <= req_tdata[RND_W+POS_W-1:RND_W];
      end
   end

   assign rd_en  = cmd.rd_read | cmd.rd_swap;
   assign addr_a = cmd.rd_read ? idx_ff : pos_ff;
   assign addr_b = rem;

   always_ff @(posedge clock) begin
      if (cmd.wr_pos) begin
         deck_ff[addr_a_ff] <= card_b;
      end else if (cmd.wr_j) begin
         deck_ff[addr_b_ff] <= card_a;
      end
      if (rd_en) begin
         rd_a_ff <= deck_ff[addr_a];
         rd_b_ff <= deck_ff[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         addr_a_ff <= addr_a;
         addr_b_ff <= addr_b;
         vld_a_ff  <= valid_ff[addr_a];
         vld_b_ff  <= valid_ff[addr_b];
      end
   end

   assign card_a = vld_a_ff ? rd_a_ff : CODE_W'(addr_a_ff);
   assign card_b = vld_b_ff ? rd_b_ff : CODE_W'(addr_b_ff);

   always_comb begin
      valid_in = valid_ff;
      pos_in   = pos_ff;
      if (cmd.clear_deck) begin
         valid_in = '0;
         pos_in   = TOP_POS;
      end
      if (cmd.wr_pos) begin
         valid_in[addr_a_ff] = 1'b1;
      end
      if (cmd.wr_j) begin
         valid_in[addr_b_ff] = 1'b1;
         pos_in              = pos_ff - 1'b1;
      end
   end

   always_comb begin
      res_code_in = res_code_ff;
      res_has_in  = res_has_ff;
      res_stat_in = res_stat_ff;
      if (cmd.res_init) begin
         res_has_in  = 1'b0;
         res_stat_in = cmd.res_status;
      end
      if (cmd.res_from_a) begin
         res_code_in = card_a;
         res_has_in  = 1'b1;
      end
      if (cmd.wr_pos) begin
         res_code_in = card_b;
         res_has_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         pos_ff      <= TOP_POS;
         res_has_ff  <= 1'b0;
         res_stat_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         pos_ff      <= pos_in;
         res_has_ff  <= res_has_in;
         res_stat_ff <= res_stat_in;
      end
      res_code_ff <= res_code_in;
   end

   assign out_value = res_has_ff ? card_value(res_code_ff) : 4'd0;
   assign out_suit  = res_has_ff ? res_code_ff[1:0] : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_data_ff <= {4'd0, pos_ff, out_suit, out_value};
         rsp_user_ff <= res_stat_ff;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;
   assign rsp_tuser     = rsp_user_ff;

   assign stat.action   = act_ff;
   assign stat.pos_ok   = (pos_ff != '0) && ({1'b0, pos_ff} < DECK_SIZE_V);
   assign stat.idx_ok   = {1'b0, idx_ff} < DECK_SIZE_V;
   assign stat.div_done = div_done;
   assign stat.out_free = ~rsp_valid_ff | rsp_tready;

endmodule

@@ src/cds_ctrl.sv @@
// Sequencer for start, swap and read transactions.
module cds_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  cds_pkg::cds_stat_type  stat,
   output cds_pkg::cds_cmd_type   cmd
);
   import cds_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_DIV    = 4'd2;
   localparam logic [3:0] S_WR_P   = 4'd3;
   localparam logic [3:0] S_WR_J   = 4'd4;
   localparam logic [3:0] S_RD_GET = 4'd5;
   localparam logic [3:0] S_EMIT   = 4'd6;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.res_init = 1'b1;
            state_in     = S_EMIT;
            unique case (stat.action)
               ACT_START: cmd.clear_deck = 1'b1;
               ACT_SWAP: begin
                  if (stat.pos_ok) begin
                     cmd.div_start = 1'b1;
                     state_in      = S_DIV;
                  end else begin
                     cmd.res_status = 1'b1;
                  end
               end
               ACT_READ: begin
                  if (stat.idx_ok) begin
                     cmd.rd_read = 1'b1;
                     state_in    = S_RD_GET;
                  end
               end
               default: ;
            endcase
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.rd_swap = 1'b1;
               state_in    = S_WR_P;
            end
         end
         S_WR_P: begin
            cmd.wr_pos = 1'b1;
            state_in   = S_WR_J;
         end
         S_WR_J: begin
            cmd.wr_j = 1'b1;
            state_in = S_EMIT;
         end
         S_RD_GET: begin
            cmd.res_from_a = 1'b1;
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

@@ src/card_deck_shuffler.sv @@
// Card deck shuffler top level: at most one Fisher-Yates swap per transaction.
//
// Request channel (req_*): tuser carries the action (start, swap, read),
// tdata carries the random word and the card index. Every request gives
// exactly one response transaction (rsp_*) with card value, suit, the
// number of swap steps left and, in tuser, a flag for a swap issued after
// the shuffle has finished.
// One request is handled at a time. Start, unused codes, rejected swaps
// and off-deck reads go from decode straight to the response; reads add
// a deck read; swaps wait for the remainder unit, which retires one random
// bit per cycle, and take two writes on the single-write-port deck memory.
// The next request is accepted the cycle after a response is loaded, so
// one response can wait in the output register while the next request
// is in work; a stalled receiver holds the sequencer before it loads its
// next response.
// Reset (synchronous) puts the deck in order and the swap position at the
// top by clearing per-entry valid bits; a start request does the same.
module card_deck_shuffler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // random_value[15:0], card_index[21:16], zero pad
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // card_value[3:0], card_suit[5:4], steps_left[11:6], pad
   output logic [0:0]  rsp_tuser    // status[0]
);
   import cds_pkg::*;

   cds_cmd_type  cmd;
   cds_stat_type stat;

   cds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cds_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ tb/card_deck_shuffler_tb.sv @@
// Self-checking testbench for card_deck_shuffler with a deck predictor.
`timescale 1ns / 100ps

module card_deck_shuffler_tb;
   import cds_pkg::*;

   localparam logic [1:0] ACT_UNUSED  = 2'd3;
   localparam int         ITEM_TARGET = 850;
   localparam int         IDLE_LIMIT  = 4000;
   localparam int         HOLD_AT     = 300;
   localparam int         HOLD_CYCLES = 400;
   localparam int         DRAIN_WAIT  = 40;

   typedef struct {
      logic [1:0]  action;
      logic [15:0] word;
      logic [5:0]  index;
      bit          drain;
   } deal_item_type;

   typedef struct packed {
      logic [3:0] value;
      logic [1:0] suit;
      logic [5:0] steps;
      logic       status;
   } card_report_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;  // random_value[15:0], card_index[21:16], zero pad
   logic [1:0]  req_tuser  = '0;  // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // card_value[3:0], card_suit[5:4], steps_left[11:6], pad
   logic [0:0]  rsp_tuser;        // status[0]

   deal_item_type   pending_items[$];
   card_report_type expected_reports[$];

   logic [5:0] deck_model[DECK_SIZE];
   logic [5:0] swap_pos;

   int  queued_items = 0;
   int  errors       = 0;
   int  responses    = 0;
   int  idle_cycles  = 0;
   int  n_starts = 0, n_swaps = 0, n_rejected = 0, n_reads = 0, n_off_deck = 0, n_unused = 0;
   bit  req_took = 1'b0;
   bit  tx_calm  = 1'b0;
   bit  rx_calm  = 1'b0;
   bit  hold_done = 1'b0;
   int  tx_gap = 0;
   int  rx_gap = 0;
   int  hold_cnt = 0;

   card_deck_shuffler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void order_deck();
      for (int i = 0; i < DECK_SIZE; i++) begin
         deck_model[i] = 6'(i);
      end
      swap_pos = 6'(DECK_SIZE - 1);
   endfunction

   function automatic void show_card(inout card_report_type rep, input logic [5:0] code);
      rep.value = 4'(code[5:2] + 4'd2);
      rep.suit  = code[1:0];
   endfunction

   function automatic card_report_type deal_step(input logic [1:0]  action,
                                                 input logic [15:0] word,
                                                 input logic [5:0]  index);
      card_report_type rep;
      int              p;
      int              j;
      logic [5:0]      held;
      rep = '0;
      unique case (action)
         ACT_START: begin
            order_deck();
            n_starts++;
         end
         ACT_SWAP: begin
            p = int'(swap_pos);
            if (p == 0 || p >= DECK_SIZE) begin
               rep.status = 1'b1;
               n_rejected++;
            end else begin
               j = int'(word) % (p + 1);
               held = deck_model[p];
               deck_model[p] = deck_model[j];
               deck_model[j] = held;
               show_card(rep, deck_model[p]);
               swap_pos = 6'(p - 1);
               n_swaps++;
            end
         end
         ACT_READ: begin
            if (int'(index) < DECK_SIZE) show_card(rep, deck_model[index]);
            else n_off_deck++;
            n_reads++;
         end
         default: begin
            n_unused++;
         end
      endcase
      rep.steps = swap_pos;
      return rep;
   endfunction

   task automatic add_item(input logic [1:0] action, input logic [15:0] word,
                           input logic [5:0] index, input bit drain = 1'b0);
      deal_item_type it;
      it.action = action;
      it.word   = word;
      it.index  = index;
      it.drain  = drain;
      pending_items.push_back(it);
      if (action != ACT_UNUSED) queued_items++;
   endtask

   function automatic logic [15:0] pick_word();
      unique case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 63));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [5:0] pick_index();
      if ($urandom_range(0, 99) < 85) return 6'($urandom_range(0, DECK_SIZE - 1));
      return 6'($urandom_range(DECK_SIZE, 63));
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // request driver
   always @(negedge clock) begin
      bit            nxt_valid;
      deal_item_type it;
      nxt_valid = req_tvalid;
      if (!reset && (!req_tvalid || req_took)) begin
         nxt_valid = 1'b0;
         if (tx_gap > 0) begin
            tx_gap--;
         end else if (pending_items.size() != 0 &&
                      !(pending_items[0].drain && expected_reports.size() != 0)) begin
            it = pending_items.pop_front();
            req_tdata <= {2'b00, it.index, it.word};
            req_tuser <= it.action;
            nxt_valid = 1'b1;
            if ($urandom_range(0, 49) == 0) tx_calm = ~tx_calm;
            tx_gap = tx_calm ? 0 : pick_gap();
         end
      end
      req_tvalid <= nxt_valid;
   end

   // response receiver
   always @(negedge clock) begin
      bit nxt_ready;
      nxt_ready = 1'b0;
      if (!reset) begin
         if (hold_cnt > 0) begin
            hold_cnt--;
         end else if (responses >= HOLD_AT && !hold_done) begin
            hold_done = 1'b1;
            hold_cnt  = HOLD_CYCLES;
         end else if (rx_gap > 0) begin
            rx_gap--;
         end else begin
            nxt_ready = 1'b1;
            if ($urandom_range(0, 49) == 0) rx_calm = ~rx_calm;
            if (!rx_calm && $urandom_range(0, 3) == 0) rx_gap = pick_gap();
         end
      end
      rsp_tready <= nxt_ready;
   end

   // monitor and checker
   always @(posedge clock) begin
      card_report_type want;
      card_report_type got;
      req_took <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_reports.push_back(deal_step(req_tuser, req_tdata[15:0],
                                                 req_tdata[21:16]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.value  = rsp_tdata[3:0];
            got.suit   = rsp_tdata[5:4];
            got.steps  = rsp_tdata[11:6];
            got.status = rsp_tuser[0];
            responses++;
            if (expected_reports.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected response: value %0d suit %0d steps %0d status %0d",
                           got.value, got.suit, got.steps, got.status);
            end else begin
               want = expected_reports.pop_front();
               if (got.value !== want.value || got.suit !== want.suit ||
                   got.steps !== want.steps || got.status !== want.status) begin
                  errors++;
                  if (errors <= 10)
                     $display({"response %0d mismatch: value %0d/%0d suit %0d/%0d ",
                               "steps %0d/%0d status %0d/%0d (exp/got)"},
                              responses, want.value, got.value, want.suit, got.suit,
                              want.steps, got.steps, want.status, got.status);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("card_deck_shuffler_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int n_swap_run;
      order_deck();

      // directed: reset deck, edges of the index and word, unused code, restart
      add_item(ACT_READ, 16'h0000, 6'd0);
      add_item(ACT_READ, 16'hFFFF, 6'(DECK_SIZE - 1));
      add_item(ACT_READ, 16'h0000, 6'(DECK_SIZE));
      add_item(ACT_READ, 16'hFFFF, 6'd63);
      add_item(ACT_UNUSED, 16'hFFFF, 6'd63);
      add_item(ACT_SWAP, 16'h0000, 6'd0);
      add_item(ACT_SWAP, 16'hFFFF, 6'd63);
      add_item(ACT_SWAP, 16'd49, 6'd0);
      add_item(ACT_READ, 16'h0000, 6'(DECK_SIZE - 1));
      add_item(ACT_READ, 16'h0000, 6'(DECK_SIZE - 2));
      add_item(ACT_READ, 16'h0000, 6'd0);
      add_item(ACT_START, 16'hFFFF, 6'd63);
      add_item(ACT_READ, 16'h0000, 6'(DECK_SIZE - 1));
      add_item(ACT_SWAP, 16'h8000, 6'd42);
      add_item(ACT_SWAP, 16'h0001, 6'd21);
      add_item(ACT_READ, 16'h5555, 6'd0, 1'b1);

      while (queued_items < ITEM_TARGET) begin
         if ($urandom_range(0, 9) < 8) begin
            // a deal, sometimes cut short
            add_item(ACT_START, pick_word(), pick_index(), $urandom_range(0, 3) == 0);
            n_swap_run = ($urandom_range(0, 4) == 0) ? $urandom_range(1, DECK_SIZE - 2)
                                                     : DECK_SIZE - 1;
            for (int s = 0; s < n_swap_run; s++) begin
               add_item(ACT_SWAP, pick_word(), pick_index());
               if ($urandom_range(0, 4) == 0) add_item(ACT_READ, pick_word(), pick_index());
            end
            if (n_swap_run == DECK_SIZE - 1) begin
               repeat ($urandom_range(1, 3)) add_item(ACT_SWAP, pick_word(), pick_index());
            end
            repeat ($urandom_range(1, 4)) add_item(ACT_READ, pick_word(), pick_index());
         end else begin
            repeat ($urandom_range(4, 12))
               add_item(2'($urandom_range(0, 3)), 16'($urandom), 6'($urandom_range(0, 63)));
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_tvalid || expected_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_reports.size() != 0) errors++;

      $display("run: %0d deals started, %0d swaps, %0d swaps past the end, %0d unused codes",
               n_starts, n_swaps, n_rejected, n_unused);
      $display("run: %0d reads (%0d off the deck), %0d responses checked, %0d errors",
               n_reads, n_off_deck, responses, errors);
      if (errors == 0) begin
         $display("card_deck_shuffler_tb: done, clean");
      end else begin
         $display("card_deck_shuffler_tb: done, errors");
      end
      $finish;
   end

endmodule
